### design/assert_macros.svh
// Assertion macros used by the design file of the successor-with-delete block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked property that is switched off while reset is applied.
`define SDUF_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked property that is checked at every edge, reset included.
`define SDUF_ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SDUF_ASSERT_RST(label, clk, rstn, prop, msg)
`define SDUF_ASSERT_CLK(label, clk, prop, msg)

`endif

`endif

### design/sduf_pkg.sv
// Types and codes of the successor-with-delete union-find block.
`default_nettype none

package sduf_pkg;

    // Operation codes carried in the input tuser bit.
    localparam logic KIND_DELETE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // Fixed widths of the stream fields.
    localparam int INDEX_W = 8;
    localparam int SUCC_W  = 9;
    localparam int OUT_W   = 16;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_ISSUE  = 7'b0000100,
        ST_WALK   = 7'b0001000,
        ST_LOSER  = 7'b0010000,
        ST_WINNER = 7'b0100000,
        ST_RESULT = 7'b1000000
    } state_t;

    // Which root walk is running.
    typedef enum logic [1:0] {
        PH_DEL_A     = 2'd0,
        PH_DEL_B     = 2'd1,
        PH_QRY_SUCC  = 2'd2,
        PH_QRY_PRES  = 2'd3
    } phase_t;

endpackage

`default_nettype wire

### design/successor_delete_union_find.sv
// Successor-with-delete set built on a weighted union-find forest in one memory.
//
//  channel | dir | ports                       | contents
//  --------+-----+-----------------------------+-----------------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata   | tdata[7:0] index, tuser[0] kind
//          |     | s_tuser                     | (0 delete, 1 query)
//  m_      | out | m_tvalid m_tready m_tdata   | tdata[8:0] successor, [9] no_successor,
//          |     |                             | [10] present, [15:11] zero
//
// After reset the block sweeps all UNIVERSE+1 entries of the forest memory, one entry a
// cycle, and s_tready stays low during that sweep.
// A query walks to the roots of index+1 and then of index; the first root's maxv is the
// successor, and the second tells whether index is present. A delete first walks from
// index and index+1 as well, then writes the loser root and the winner root to merge
// them unless both already share a root, and then answers with the walks of a query.
// Union by size keeps each path within log2(UNIVERSE+1), and each walk follows one
// parent link per cycle through the single read port of the memory.
// One item is in flight at a time: s_tready is high only while idle, and the result
// holds on m_tdata until m_tready takes it.
`default_nettype none

`include "assert_macros.svh"

module successor_delete_union_find #(
    parameter int UNIVERSE = 256
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Input item: tdata[7:0] index.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [sduf_pkg::INDEX_W-1:0]  s_tdata,
    // Input item: tuser[0] kind.
    input  wire logic                          s_tuser,
    // Result item: [8:0] successor, [9] no_successor, [10] present, rest zero.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [sduf_pkg::OUT_W-1:0]         m_tdata
);

    // Forest geometry: entry UNIVERSE is the sentinel that is never deleted.
    localparam int ENTRIES = UNIVERSE + 1;
    localparam int EW      = $clog2(ENTRIES);
    // A component can hold every entry, so the size field must reach ENTRIES.
    localparam int SW      = $clog2(ENTRIES + 1);

    typedef struct packed {
        logic [EW-1:0] parent;
        logic [SW-1:0] size;
        logic [EW-1:0] maxv;
    } entry_t;

    // Forest memory: one write and one registered read per cycle.
    entry_t entry_mem [ENTRIES];

    sduf_pkg::state_t state_reg, state_next;
    sduf_pkg::phase_t phase_reg, phase_next;

    logic [EW-1:0]                 clr_cnt_reg, clr_cnt_next;
    logic [sduf_pkg::INDEX_W-1:0]  idx_reg, idx_next;
    logic [EW-1:0]                 cur_reg, cur_next;
    logic [EW-1:0]                 a_root_reg, a_root_next;
    logic [EW-1:0]                 b_root_reg, b_root_next;
    entry_t                        a_ent_reg, a_ent_next;
    entry_t                        b_ent_reg, b_ent_next;
    logic [EW-1:0]                 succ_reg, succ_next;
    logic                          pres_reg, pres_next;
    entry_t                        rd_data_reg;

    logic [EW-1:0] rd_addr;
    logic          wr_en;
    logic [EW-1:0] wr_addr;
    entry_t        wr_data;

    logic [EW-1:0] idx_ent;
    logic [EW-1:0] idx_plus1;
    logic [EW-1:0] walk_start;
    logic          root_found;
    logic          win_is_a;
    logic [EW-1:0] win_root;
    logic [EW-1:0] max_merged;
    logic          no_succ;

    // The index is known to be below UNIVERSE whenever it is used here, so it fits EW.
    assign idx_ent   = EW'(idx_reg);
    assign idx_plus1 = idx_ent + EW'(1);

    // Walks for the index itself start at index, the others at index+1.
    assign walk_start = (phase_reg == sduf_pkg::PH_DEL_A || phase_reg == sduf_pkg::PH_QRY_PRES)
                        ? idx_ent : idx_plus1;

    // A root is an entry that points at itself.
    assign root_found = (rd_data_reg.parent == cur_reg);

    // Union by size: the index side wins only when strictly larger.
    assign win_is_a   = (a_ent_reg.size > b_ent_reg.size);
    assign win_root   = win_is_a ? a_root_reg : b_root_reg;
    assign max_merged = (a_ent_reg.maxv > b_ent_reg.maxv) ? a_ent_reg.maxv : b_ent_reg.maxv;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

    // Memory write selection: reset sweep, then the two writes of a merge.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        case (state_reg)
            sduf_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '{parent: clr_cnt_reg, size: SW'(1), maxv: clr_cnt_reg};
            end
            sduf_pkg::ST_LOSER: begin
                wr_en   = 1'b1;
                wr_addr = win_is_a ? b_root_reg : a_root_reg;
                wr_data = win_is_a ? b_ent_reg : a_ent_reg;
                wr_data.parent = win_root;
            end
            sduf_pkg::ST_WINNER: begin
                wr_en   = 1'b1;
                wr_addr = win_root;
                wr_data = '{parent: win_root,
                            size:   a_ent_reg.size + b_ent_reg.size,
                            maxv:   max_merged};
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        clr_cnt_next = clr_cnt_reg;
        idx_next     = idx_reg;
        cur_next     = cur_reg;
        a_root_next  = a_root_reg;
        b_root_next  = b_root_reg;
        a_ent_next   = a_ent_reg;
        b_ent_next   = b_ent_reg;
        succ_next    = succ_reg;
        pres_next    = pres_reg;
        rd_addr      = cur_reg;
        case (state_reg)
            sduf_pkg::ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + EW'(1);
                if (clr_cnt_reg == EW'(UNIVERSE)) begin
                    state_next = sduf_pkg::ST_IDLE;
                end
            end
            sduf_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    idx_next = s_tdata;
                    if (32'(s_tdata) >= 32'(UNIVERSE)) begin
                        // Outside the set: nothing changes, and the answer is fixed.
                        succ_next  = EW'(UNIVERSE);
                        pres_next  = 1'b0;
                        state_next = sduf_pkg::ST_RESULT;
                    end else begin
                        phase_next = (s_tuser == sduf_pkg::KIND_DELETE)
                                     ? sduf_pkg::PH_DEL_A : sduf_pkg::PH_QRY_SUCC;
                        state_next = sduf_pkg::ST_ISSUE;
                    end
                end
            end
            sduf_pkg::ST_ISSUE: begin
                rd_addr    = walk_start;
                cur_next   = walk_start;
                state_next = sduf_pkg::ST_WALK;
            end
            sduf_pkg::ST_WALK: begin
                if (!root_found) begin
                    rd_addr  = rd_data_reg.parent;
                    cur_next = rd_data_reg.parent;
                end else begin
                    case (phase_reg)
                        sduf_pkg::PH_DEL_A: begin
                            a_root_next = cur_reg;
                            a_ent_next  = rd_data_reg;
                            phase_next  = sduf_pkg::PH_DEL_B;
                            state_next  = sduf_pkg::ST_ISSUE;
                        end
                        sduf_pkg::PH_DEL_B: begin
                            b_root_next = cur_reg;
                            b_ent_next  = rd_data_reg;
                            if (cur_reg == a_root_reg) begin
                                // Already merged: the delete changes nothing.
                                phase_next = sduf_pkg::PH_QRY_SUCC;
                                state_next = sduf_pkg::ST_ISSUE;
                            end else begin
                                state_next = sduf_pkg::ST_LOSER;
                            end
                        end
                        sduf_pkg::PH_QRY_SUCC: begin
                            succ_next  = rd_data_reg.maxv;
                            phase_next = sduf_pkg::PH_QRY_PRES;
                            state_next = sduf_pkg::ST_ISSUE;
                        end
                        sduf_pkg::PH_QRY_PRES: begin
                            pres_next  = (rd_data_reg.maxv == idx_ent);
                            state_next = sduf_pkg::ST_RESULT;
                        end
                        default: begin
                            state_next = sduf_pkg::ST_RESULT;
                        end
                    endcase
                end
            end
            sduf_pkg::ST_LOSER: begin
                state_next = sduf_pkg::ST_WINNER;
            end
            sduf_pkg::ST_WINNER: begin
                // After the merge the result is answered by a fresh query.
                phase_next = sduf_pkg::PH_QRY_SUCC;
                state_next = sduf_pkg::ST_ISSUE;
            end
            sduf_pkg::ST_RESULT: begin
                if (m_tready) begin
                    state_next = sduf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sduf_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sduf_pkg::ST_CLEAR;
            phase_reg   <= sduf_pkg::PH_QRY_SUCC;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        cur_reg    <= cur_next;
        a_root_reg <= a_root_next;
        b_root_reg <= b_root_next;
        a_ent_reg  <= a_ent_next;
        b_ent_reg  <= b_ent_next;
        succ_reg   <= succ_next;
        pres_reg   <= pres_next;
    end

    // The sentinel as successor means nothing present lies above the index.
    assign no_succ = (succ_reg == EW'(UNIVERSE));

    assign s_tready = (state_reg == sduf_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == sduf_pkg::ST_RESULT);
    assign m_tdata  = {5'd0, pres_reg, no_succ, sduf_pkg::SUCC_W'(succ_reg)};

    // Checks on the sequencer.
    `SDUF_ASSERT_CLK(a_reset_enters_clear, aclk, !aresetn |=> (state_reg == sduf_pkg::ST_CLEAR), "reset did not start the clearing sweep")
    `SDUF_ASSERT_RST(a_clear_blocks_input, aclk, aresetn, (state_reg == sduf_pkg::ST_CLEAR) |-> !s_tready, "input taken during the clearing sweep")
    `SDUF_ASSERT_RST(a_one_item_at_a_time, aclk, aresetn, m_tvalid |-> !s_tready, "input taken while a result waits")
    `SDUF_ASSERT_RST(a_merge_write_pair, aclk, aresetn, (state_reg == sduf_pkg::ST_LOSER) |=> (state_reg == sduf_pkg::ST_WINNER), "merge lost its second write")
    `SDUF_ASSERT_RST(a_no_succ_code, aclk, aresetn, (m_tvalid && m_tdata[9]) |-> (m_tdata[8:0] == 9'(UNIVERSE)), "no_successor set without the sentinel code")

endmodule

`default_nettype wire
